@@ rtl/ljpf_pkg.sv @@
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared widths, status codes, pipeline side-band type and divider step for
// the Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int AD_W      = POS_W;                   // |first - second| fits unsigned
	localparam int SQ_W      = 2 * AD_W;
	localparam int R2_W      = SQ_W - FRAC_BITS + 2;    // sum of three truncated squares
	localparam int SIG_W     = 32;
	localparam int SIG2_W    = 2 * SIG_W;
	localparam int CAP_W     = 62;                      // intermediates saturate at 2^62-1
	localparam int DIVD_W    = CAP_W + FRAC_BITS;
	localparam int REM_W     = R2_W + 1;
	localparam int HALF_W    = 32;
	localparam int MUL_W     = 2 * HALF_W;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int EPS24_W   = SIG_W + 5;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CAP_W-1:0] CAP = {CAP_W{1'b1}};
	localparam logic [POS_W-1:0] POS_LIM = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] NEG_LIM = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [SIG_W-1:0] ONE_Q   = SIG_W'(1) << FRAC_BITS;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
	localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd1;

	// Per-pair context carried alongside the arithmetic units
	typedef struct packed {
		logic [2:0][AD_W-1:0] ad;
		logic [2:0]           neg;
		logic                 zero;
		logic [R2_W-1:0]      r2;
		logic                 ovf;
		logic [CAP_W-1:0]     q;
		logic [CAP_W-1:0]     q3;
		logic                 attract;
	} side_t;

	typedef struct packed {
		logic signed [POS_W-1:0] force_x;
		logic signed [POS_W-1:0] force_y;
		logic signed [POS_W-1:0] force_z;
		logic [ST_W-1:0]         status;
	} res_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             qbit;
	} dstep_t;

	// One restoring division step: bring in the next dividend bit, subtract if it fits
	function automatic dstep_t div_step(input logic [REM_W-1:0] rem, input logic nb,
		input logic [R2_W-1:0] b);
		logic [REM_W:0] t;
		logic [REM_W:0] d;
		dstep_t r;
		t = {rem, nb};
		d = t - (REM_W + 1)'(b);
		if (t >= (REM_W + 1)'(b)) begin
			r.rem  = d[REM_W-1:0];
			r.qbit = 1'b1;
		end else begin
			r.rem  = t[REM_W-1:0];
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ rtl/ljpf_if.sv @@
// ----------------------------------------------------------------------------
// ljpf_if
// Valid/ready channels: particle pair in, force result out.
// ----------------------------------------------------------------------------
interface ljpf_pair_if;
	logic                              valid;
	logic                              ready;
	logic signed [ljpf_pkg::POS_W-1:0] first_x;
	logic signed [ljpf_pkg::POS_W-1:0] first_y;
	logic signed [ljpf_pkg::POS_W-1:0] first_z;
	logic signed [ljpf_pkg::POS_W-1:0] second_x;
	logic signed [ljpf_pkg::POS_W-1:0] second_y;
	logic signed [ljpf_pkg::POS_W-1:0] second_z;

	modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input ready);
	modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready);
endinterface

interface ljpf_force_if;
	logic                              valid;
	logic                              ready;
	logic signed [ljpf_pkg::POS_W-1:0] force_x;
	logic signed [ljpf_pkg::POS_W-1:0] force_y;
	logic signed [ljpf_pkg::POS_W-1:0] force_z;
	logic [ljpf_pkg::ST_W-1:0]         status;

	modport source(output valid, force_x, force_y, force_z, status, input ready);
	modport sink(input valid, force_x, force_y, force_z, status, output ready);
endinterface

@@ rtl/ljpf_mul.sv @@
// ----------------------------------------------------------------------------
// ljpf_mul
// Three-stage 64x64 multiply, shift right by the fraction bits, saturate at
// the intermediate ceiling. Side-band context travels with the product.
// ----------------------------------------------------------------------------
module ljpf_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  logic [ljpf_pkg::MUL_W-1:0]  a_i,
	input  logic [ljpf_pkg::MUL_W-1:0]  b_i,
	input  ljpf_pkg::side_t             side_i,
	output logic                        vld_o,
	output logic [ljpf_pkg::CAP_W-1:0]  res_o,
	output logic                        ovf_o,
	output ljpf_pkg::side_t             side_o
);
	import ljpf_pkg::*;

	localparam int SH_W = PROD_W - FRAC_BITS;

	logic [MUL_W-1:0]  pll_s1, plh_s1, phl_s1, phh_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [CAP_W-1:0]  res_s3;
	logic              ovf_s3;
	side_t             side_s1, side_s2, side_s3;
	logic              vld_s1, vld_s2, vld_s3;

	logic [HALF_W+1:0] mid;
	logic [MUL_W-1:0]  hi;
	logic [SH_W-1:0]   sh;

	always_comb begin
		mid = (HALF_W + 2)'(pll_s1[MUL_W-1:HALF_W]) + (HALF_W + 2)'(plh_s1[HALF_W-1:0])
			+ (HALF_W + 2)'(phl_s1[HALF_W-1:0]);
		hi  = phh_s1 + MUL_W'(plh_s1[MUL_W-1:HALF_W]) + MUL_W'(phl_s1[MUL_W-1:HALF_W])
			+ MUL_W'(mid[HALF_W+1:HALF_W]);
		sh  = prod_s2[PROD_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1  <= a_i[HALF_W-1:0] * b_i[HALF_W-1:0];
			plh_s1  <= a_i[HALF_W-1:0] * b_i[MUL_W-1:HALF_W];
			phl_s1  <= a_i[MUL_W-1:HALF_W] * b_i[HALF_W-1:0];
			phh_s1  <= a_i[MUL_W-1:HALF_W] * b_i[MUL_W-1:HALF_W];
			side_s1 <= side_i;
			prod_s2 <= {hi, mid[HALF_W-1:0], pll_s1[HALF_W-1:0]};
			side_s2 <= side_s1;
			ovf_s3  <= |sh[SH_W-1:CAP_W];
			res_s3  <= (|sh[SH_W-1:CAP_W]) ? CAP : sh[CAP_W-1:0];
			side_s3 <= side_s2;
		end
	end

	assign vld_o  = vld_s3;
	assign res_o  = res_s3;
	assign ovf_o  = ovf_s3;
	assign side_o = side_s3;

endmodule

@@ rtl/ljpf_div.sv @@
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider, one quotient bit per stage, by the pair's
// squared distance. Flags a quotient above the intermediate ceiling.
// ----------------------------------------------------------------------------
module ljpf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  logic [ljpf_pkg::DIVD_W-1:0] dvd_i,
	input  ljpf_pkg::side_t             side_i,
	output logic                        vld_o,
	output logic [ljpf_pkg::CAP_W-1:0]  quo_o,
	output logic                        ovf_o,
	output ljpf_pkg::side_t             side_o
);
	import ljpf_pkg::*;

	localparam int N = CAP_W;

	logic [N-1:0]     vld_s;
	logic [REM_W-1:0] rem_s  [N];
	logic [CAP_W-1:0] low_s  [N];
	logic [CAP_W-1:0] quo_s  [N];
	logic             ovf_s  [N];
	side_t            side_s [N];

	logic [REM_W-1:0] rem_p  [N];
	logic [CAP_W-1:0] low_p  [N];
	logic [CAP_W-1:0] quo_p  [N];
	logic             ovf_p  [N];
	side_t            side_p [N];
	dstep_t           st     [N];

	always_comb begin
		rem_p[0]  = REM_W'(dvd_i[DIVD_W-1:CAP_W]);
		low_p[0]  = dvd_i[CAP_W-1:0];
		quo_p[0]  = '0;
		// quotient reaches 2^62 when the top dividend bits alone cover the divisor
		ovf_p[0]  = R2_W'(dvd_i[DIVD_W-1:CAP_W]) >= side_i.r2;
		side_p[0] = side_i;
		for (int j = 1; j < N; j++) begin
			rem_p[j]  = rem_s[j-1];
			low_p[j]  = low_s[j-1];
			quo_p[j]  = quo_s[j-1];
			ovf_p[j]  = ovf_s[j-1];
			side_p[j] = side_s[j-1];
		end
		for (int j = 0; j < N; j++) begin
			st[j] = div_step(rem_p[j], low_p[j][CAP_W-1], side_p[j].r2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < N; j++) begin
				rem_s[j]  <= st[j].rem;
				low_s[j]  <= {low_p[j][CAP_W-2:0], 1'b0};
				quo_s[j]  <= {quo_p[j][CAP_W-2:0], st[j].qbit};
				ovf_s[j]  <= ovf_p[j];
				side_s[j] <= side_p[j];
			end
		end
	end

	assign vld_o  = vld_s[N-1];
	assign quo_o  = quo_s[N-1];
	assign ovf_o  = ovf_s[N-1];
	assign side_o = side_s[N-1];

endmodule

@@ rtl/lennard_jones_pair_force.sv @@
// ----------------------------------------------------------------------------
// lennard_jones_pair_force
// Lennard-Jones 12-6 pair force on the first particle, signed Q16.16.
// Accepts one pair per cycle while the skid stage is empty.
// Latency is set by the two 62-stage dividers (sig^2/r^2 and k/r^2) plus
// five 3-stage multipliers and five single stages.
// Reset clears all valid bits and the skid stage; scales return to 1.0.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ljpf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [ljpf_pkg::SIG_W-1:0]     wr_data,
	ljpf_pair_if.sink                      pair,
	ljpf_force_if.source                   result
);
	import ljpf_pkg::*;

	logic [SIG_W-1:0] energy_scale_q, length_scale_q;
	logic             en;
	logic             skid_valid_q;
	res_t             skid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_scale_q <= ONE_Q;
			length_scale_q <= ONE_Q;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ENERGY: energy_scale_q <= wr_data;
				CFG_LENGTH: length_scale_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage 1: separation and magnitude
	logic signed [POS_W-1:0] fst [3];
	logic signed [POS_W-1:0] snd [3];
	logic [AD_W:0]           dd  [3];
	logic [AD_W:0]           dn  [3];
	logic [AD_W-1:0]         ad_s1 [3];
	logic [2:0]              neg_s1;
	logic                    vld_s1;

	always_comb begin
		fst[0] = pair.first_x;
		fst[1] = pair.first_y;
		fst[2] = pair.first_z;
		snd[0] = pair.second_x;
		snd[1] = pair.second_y;
		snd[2] = pair.second_z;
		for (int i = 0; i < 3; i++) begin
			dd[i] = {fst[i][POS_W-1], fst[i]} - {snd[i][POS_W-1], snd[i]};
			dn[i] = -dd[i];
		end
	end

	// stage 2: squares
	logic [SQ_W-1:0]   sq_s2 [3];
	logic [SIG2_W-1:0] sig2_s2;
	logic [AD_W-1:0]   ad_s2 [3];
	logic [2:0]        neg_s2;
	logic              vld_s2;

	// stage 3: squared distance
	logic [R2_W-1:0]   r2_raw;
	side_t             side_s3;
	logic [SIG2_W-1:0] sig2_s3;
	logic              vld_s3;

	always_comb begin
		r2_raw = R2_W'(sq_s2[0][SQ_W-1:FRAC_BITS]) + R2_W'(sq_s2[1][SQ_W-1:FRAC_BITS])
			+ R2_W'(sq_s2[2][SQ_W-1:FRAC_BITS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pair.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= dd[i][AD_W];
				ad_s1[i]  <= dd[i][AD_W] ? dn[i][AD_W-1:0] : dd[i][AD_W-1:0];
				sq_s2[i]  <= ad_s1[i] * ad_s1[i];
				ad_s2[i]  <= ad_s1[i];
				side_s3.ad[i] <= ad_s2[i];
			end
			neg_s2          <= neg_s1;
			sig2_s2         <= length_scale_q * length_scale_q;
			side_s3.neg     <= neg_s2;
			side_s3.zero    <= (ad_s2[0] == '0) && (ad_s2[1] == '0) && (ad_s2[2] == '0);
			// distance below resolution counts as one LSB
			side_s3.r2      <= (r2_raw == '0) ? R2_W'(1) : r2_raw;
			side_s3.ovf     <= 1'b0;
			side_s3.q       <= '0;
			side_s3.q3      <= '0;
			side_s3.attract <= 1'b0;
			sig2_s3         <= sig2_s2;
		end
	end

	// q = sig^2 / r^2
	logic             vld_d1;
	logic [CAP_W-1:0] quo_d1;
	logic             ovf_d1;
	side_t            side_d1, side_m1;

	ljpf_div u_div_q (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.dvd_i  (DIVD_W'(sig2_s3)),
		.side_i (side_s3),
		.vld_o  (vld_d1),
		.quo_o  (quo_d1),
		.ovf_o  (ovf_d1),
		.side_o (side_d1)
	);

	always_comb begin
		side_m1     = side_d1;
		side_m1.q   = ovf_d1 ? CAP : quo_d1;
		side_m1.ovf = ovf_d1;
	end

	// powers of q
	logic             vld_m1, vld_m2, vld_m3;
	logic [CAP_W-1:0] q2_m1, q3_m2, q6_m3;
	logic             ovf_m1, ovf_m2, ovf_m3;
	side_t            side_m1o, side_m2, side_m2o, side_m3, side_m3o;

	ljpf_mul u_mul_q2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_d1),
		.a_i    (MUL_W'(side_m1.q)),
		.b_i    (MUL_W'(side_m1.q)),
		.side_i (side_m1),
		.vld_o  (vld_m1),
		.res_o  (q2_m1),
		.ovf_o  (ovf_m1),
		.side_o (side_m1o)
	);

	always_comb begin
		side_m2     = side_m1o;
		side_m2.ovf = side_m1o.ovf | ovf_m1;
	end

	ljpf_mul u_mul_q3 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_m1),
		.a_i    (MUL_W'(q2_m1)),
		.b_i    (MUL_W'(side_m1o.q)),
		.side_i (side_m2),
		.vld_o  (vld_m2),
		.res_o  (q3_m2),
		.ovf_o  (ovf_m2),
		.side_o (side_m2o)
	);

	always_comb begin
		side_m3     = side_m2o;
		side_m3.q3  = q3_m2;
		side_m3.ovf = side_m2o.ovf | ovf_m2;
	end

	ljpf_mul u_mul_q6 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_m2),
		.a_i    (MUL_W'(q3_m2)),
		.b_i    (MUL_W'(q3_m2)),
		.side_i (side_m3),
		.vld_o  (vld_m3),
		.res_o  (q6_m3),
		.ovf_o  (ovf_m3),
		.side_o (side_m3o)
	);

	// stage 4: repulsive minus attractive term
	logic [CAP_W:0] rep, q3x;
	logic           att;
	side_t          side_c4;
	logic [CAP_W:0] mag_s4;
	side_t          side_s4;
	logic           vld_s4;

	always_comb begin
		rep = {q6_m3, 1'b0};
		q3x = (CAP_W + 1)'(side_m3o.q3);
		att = rep < q3x;
		side_c4         = side_m3o;
		side_c4.attract = att;
		side_c4.ovf     = side_m3o.ovf | ovf_m3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4  <= att ? (q3x - rep) : (rep - q3x);
			side_s4 <= side_c4;
		end
	end

	// k0 = 24*eps*mag
	logic [EPS24_W-1:0] eps24;
	logic               vld_m4;
	logic [CAP_W-1:0]   k0_m4;
	logic               ovf_m4;
	side_t              side_m4o, side_d2i;

	assign eps24 = {1'b0, energy_scale_q, 4'b0} + {2'b0, energy_scale_q, 3'b0};

	ljpf_mul u_mul_k0 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.a_i    (MUL_W'(eps24)),
		.b_i    (MUL_W'(mag_s4)),
		.side_i (side_s4),
		.vld_o  (vld_m4),
		.res_o  (k0_m4),
		.ovf_o  (ovf_m4),
		.side_o (side_m4o)
	);

	always_comb begin
		side_d2i     = side_m4o;
		side_d2i.ovf = side_m4o.ovf | ovf_m4;
	end

	// k = k0 / r^2
	logic             vld_d2;
	logic [CAP_W-1:0] k_d2;
	logic             ovf_d2;
	side_t            side_d2, side_m5;

	ljpf_div u_div_k (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_m4),
		.dvd_i  ({k0_m4, {FRAC_BITS{1'b0}}}),
		.side_i (side_d2i),
		.vld_o  (vld_d2),
		.quo_o  (k_d2),
		.ovf_o  (ovf_d2),
		.side_o (side_d2)
	);

	always_comb begin
		side_m5     = side_d2;
		side_m5.ovf = side_d2.ovf | ovf_d2;
	end

	// per-axis |d_i| * k
	logic             vld_m5 [3];
	logic [CAP_W-1:0] p_m5   [3];
	logic             c_m5   [3];
	side_t            side_m5o [3];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		ljpf_mul u_mul_f (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_d2),
			.a_i    (MUL_W'(side_m5.ad[i])),
			.b_i    (MUL_W'(k_d2)),
			.side_i (side_m5),
			.vld_o  (vld_m5[i]),
			.res_o  (p_m5[i]),
			.ovf_o  (c_m5[i]),
			.side_o (side_m5o[i])
		);
	end

	// stage 5: sign, clamp and status
	side_t            sd;
	logic [2:0]       fneg;
	logic [POS_W-1:0] lim  [3];
	logic [POS_W-1:0] mag_f [3];
	logic [POS_W-1:0] fval [3];
	logic [2:0]       fsat;
	res_t             res_c, res_s5;
	logic             vld_s5;

	always_comb begin
		sd = side_m5o[0];
		for (int i = 0; i < 3; i++) begin
			fneg[i] = sd.neg[i] ^ sd.attract;
			lim[i]  = fneg[i] ? NEG_LIM : POS_LIM;
			if (sd.ad[i] == '0) begin
				mag_f[i] = '0;
				fsat[i]  = 1'b0;
			end else if (sd.ovf || c_m5[i] || (p_m5[i] > CAP_W'(lim[i]))) begin
				mag_f[i] = lim[i];
				fsat[i]  = 1'b1;
			end else begin
				mag_f[i] = p_m5[i][POS_W-1:0];
				fsat[i]  = 1'b0;
			end
			fval[i] = fneg[i] ? (POS_W'(0) - mag_f[i]) : mag_f[i];
		end
		priority if (sd.zero) begin
			res_c = '0;
			res_c.status = ST_ZERO;
		end else if (energy_scale_q == '0) begin
			res_c = '0;
		end else begin
			res_c.force_x = fval[0];
			res_c.force_y = fval[1];
			res_c.force_z = fval[2];
			res_c.status  = (|fsat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_m5[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_c;
		end
	end

	// skid stage: hold a result the sink refused while the pipeline advanced
	assign en = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (result.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (vld_s5 && !result.ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_q <= res_s5;
		end
	end

	assign pair.ready     = en;
	assign result.valid   = skid_valid_q | vld_s5;
	assign result.force_x = skid_valid_q ? skid_q.force_x : res_s5.force_x;
	assign result.force_y = skid_valid_q ? skid_q.force_y : res_s5.force_y;
	assign result.force_z = skid_valid_q ? skid_q.force_z : res_s5.force_z;
	assign result.status  = skid_valid_q ? skid_q.status  : res_s5.status;

`ifndef SYNTHESIS
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !result.ready |=> skid_valid_q && $stable(skid_q))
		else $error("skid stage lost or changed a pending transaction");

	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_ZERO |->
		result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
		else $error("zero distance result carries a nonzero force");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pair.ready) |-> $past(vld_s5 && !result.ready))
		else $error("input stalled without a refused result");
`endif

endmodule
